### hw/rtl/tma_pkg.sv
package tma_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 42;
  localparam int CNT_W      = 11;
  localparam int ADDR_W     = 10;
  localparam int WINDOW_MAX = 1024;
  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(100);

  // job queue between the front and the divider
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // restoring divider, one dividend bit per step
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } tma_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [CNT_W-1:0]           samples_in_window;
  } tma_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } tma_job_t;

  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] level;
  } tma_fifo_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } tma_bk_state_t;

endpackage

### hw/rtl/tma_front.sv
module tma_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tma_pkg::tma_in_t             in_data,
  input  logic                         cfg_we,
  input  logic [tma_pkg::CNT_W-1:0]    cfg_wdata,
  input  tma_pkg::tma_fifo_status_t    fifo_st,
  output logic                         push,
  output tma_pkg::tma_job_t            push_data
);
  import tma_pkg::*;

  logic [SAMPLE_W-1:0]     mem_r [WINDOW_MAX];
  logic [SAMPLE_W-1:0]     rd_r;
  logic [ADDR_W-1:0]       wp_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        win_r;
  logic signed [SUM_W-1:0] sum_r;

  logic                    s2_v_r;
  logic [SAMPLE_W-1:0]     s2_sample_r;
  logic                    s2_sub_r;
  logic                    s2_restart_r;
  logic [CNT_W-1:0]        s2_cnt_r;

  logic                    accept;
  logic [ADDR_W-1:0]       wp_eff;
  logic [ADDR_W-1:0]       rd_addr;
  logic [CNT_W-1:0]        cnt_eff;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    full;
  logic [CNT_W-1:0]        win_eff;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] new_ext;
  logic signed [SUM_W-1:0] sum_nxt;

  // reserve a queue slot for the item sitting in stage 2
  assign in_stall = ({1'b0, fifo_st.level} + {{QCW{1'b0}}, s2_v_r}) >= (QCW+1)'(QDEPTH);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    wp_eff  = in_data.restart ? '0 : wp_r;
    cnt_eff = in_data.restart ? '0 : cnt_r;
    full    = (cnt_eff >= win_r);
    cnt_nxt = full ? cnt_eff : cnt_eff + CNT_W'(1);
    // win of WINDOW_MAX wraps onto wp itself; read-first gives the oldest entry
    rd_addr = wp_eff - win_r[ADDR_W-1:0];
  end

  always_comb begin
    if (cfg_wdata == '0) begin
      win_eff = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = cfg_wdata;
    end
  end

  always_comb begin
    base    = s2_restart_r ? '0 : sum_r;
    new_ext = {{(SUM_W-SAMPLE_W){s2_sample_r[SAMPLE_W-1]}}, s2_sample_r};
    old_ext = s2_sub_r ? {{(SUM_W-SAMPLE_W){rd_r[SAMPLE_W-1]}}, rd_r} : '0;
    sum_nxt = base + new_ext - old_ext;
  end

  assign push            = s2_v_r;
  assign push_data.sum   = sum_nxt;
  assign push_data.count = s2_cnt_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wp_eff] <= in_data.sample;
      rd_r          <= mem_r[rd_addr];
      s2_sample_r   <= in_data.sample;
      s2_sub_r      <= full;
      s2_restart_r  <= in_data.restart;
      s2_cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      win_r  <= WINDOW_RESET;
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= accept;
      if (accept) begin
        wp_r  <= wp_eff + ADDR_W'(1);
        cnt_r <= cnt_nxt;
      end
      if (s2_v_r) begin
        sum_r <= sum_nxt;
      end
      // a new window length starts a new series
      if (cfg_we) begin
        win_r <= win_eff;
        wp_r  <= '0;
        cnt_r <= '0;
        sum_r <= '0;
      end
    end
  end

endmodule

### hw/rtl/tma_fifo.sv
module tma_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  tma_pkg::tma_job_t         push_data,
  input  logic                      pop,
  output tma_pkg::tma_job_t         pop_data,
  output tma_pkg::tma_fifo_status_t status
);
  import tma_pkg::*;

  tma_job_t         entries_r [QDEPTH];
  logic [QAW-1:0]   wr_r;
  logic [QAW-1:0]   rd_r;
  logic [QCW-1:0]   level_r;
  logic [QCW-1:0]   level_nxt;

  assign pop_data     = entries_r[rd_r];
  assign status.empty = (level_r == '0);
  assign status.level = level_r;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QCW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QAW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QAW'(1);
      end
      level_r <= level_nxt;
    end
  end

endmodule

### hw/rtl/tma_div.sv
module tma_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tma_pkg::tma_fifo_status_t fifo_st,
  input  tma_pkg::tma_job_t         job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tma_pkg::tma_out_t         out_data
);
  import tma_pkg::*;

  tma_bk_state_t      state_r;
  tma_bk_state_t      state_nxt;
  logic [SUM_W-1:0]   quo_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   div_r;
  logic               neg_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  tma_out_t           out_r;

  logic               load;
  logic               finish;
  logic               out_free;
  logic [CNT_W:0]     rem_sh;
  logic               ge;
  logic [CNT_W:0]     diff;
  logic [SUM_W-1:0]   mag;
  logic [SAMPLE_W-1:0] q32;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_W-1]};
    ge     = (rem_sh >= {1'b0, div_r});
    diff   = rem_sh - {1'b0, div_r};
    mag    = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);
    q32    = neg_r ? SAMPLE_W'(-quo_r[SAMPLE_W-1:0]) : quo_r[SAMPLE_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!fifo_st.empty) begin
          load      = 1'b1;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS-1)) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r  <= mag;
      rem_r  <= '0;
      div_r  <= job.count;
      neg_r  <= job.sum[SUM_W-1];
      step_r <= '0;
    end else if (state_r == BK_DIV) begin
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      rem_r  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
    // both fields change only here, so a stalled result holds still
    if (finish) begin
      out_r.average           <= q32;
      out_r.samples_in_window <= div_r;
    end
  end

endmodule

### hw/rtl/trailing_moving_average_core.sv
// Trailing moving average, running-sum form, Q16.16 samples.
// The back end divides one item at a time with a one-bit-per-cycle divider and
// takes the next only once the last result has entered the output register; the
// front end takes items every cycle until the job queue fills.
// Reset (rst_n, synchronous): window length 100, empty series, empty queue,
// no result pending. The sample store needs no clearing.
module trailing_moving_average_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tma_pkg::tma_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tma_pkg::tma_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [tma_pkg::CNT_W-1:0] cfg_wdata
);
  import tma_pkg::*;

  // Front end: circular store, fill count and running sum. Each transfer
  // writes the new sample and reads the one leaving the window; the sum is
  // updated in the following cycle and the (sum, count) pair goes to the queue.
  logic             push;
  tma_job_t         push_data;
  logic             pop;
  tma_job_t         pop_data;
  tma_fifo_status_t fifo_st;

  tma_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fifo_st   (fifo_st),
    .push      (push),
    .push_data (push_data)
  );

  // Short job queue so the front keeps taking samples while the divider works.
  tma_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (fifo_st)
  );

  // Back end: signed sum / count, truncated toward zero, into an output
  // register that holds a valid result while out_stall is high.
  tma_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_st   (fifo_st),
    .job       (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tma_pkg::*;

  // Run guards. The divider works on one mean at a time; the cycle limit leaves
  // wide margin over the slowest correct run.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;   // catches any result beyond those expected
  localparam int unsigned HOLD_CYCLES  = 400;  // long enough to fill the job queue

  // Tracks the series state (sample window, running sum, fill count) and
  // queues the mean each accepted sample must produce.
  class window_mean_tracker;
    int                store [WINDOW_MAX];
    logic [ADDR_W-1:0] wr_pos;
    int unsigned       fill;
    longint            sum;
    logic [CNT_W-1:0]  window_reg;
    tma_out_t          expected_means [$];
    int unsigned       mismatches;

    function new();
      window_reg = WINDOW_RESET;
      mismatches = 0;
      restart_series();
    endfunction

    function void restart_series();
      sum    = 0;
      fill   = 0;
      wr_pos = '0;
    endfunction

    // A length write always starts a fresh series
    function void set_window(logic [CNT_W-1:0] len);
      window_reg = len;
      restart_series();
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction

    function void take_sample(tma_in_t item);
      int unsigned       span;
      logic [ADDR_W-1:0] oldest;
      longint            mean;
      tma_out_t          exp_mean;
      // zero acts as one, anything past the store depth saturates
      span = (window_reg == 0) ? 1 :
             ((window_reg > WINDOW_MAX) ? WINDOW_MAX : int'(window_reg));
      if (item.restart) restart_series();
      if (fill >= span) begin
        // position wraps modulo the store depth; span == depth maps to wr_pos
        oldest = wr_pos - ADDR_W'(span);
        sum -= store[oldest];
      end
      store[wr_pos] = item.sample;
      wr_pos++;
      sum += item.sample;
      if (fill < span) fill++;
      mean = sum / longint'(fill);  // truncates toward zero
      exp_mean.average           = SAMPLE_W'(mean);
      exp_mean.samples_in_window = CNT_W'(fill);
      expected_means.insert(expected_means.size(), exp_mean);
    endfunction

    function void check_mean(tma_out_t got);
      tma_out_t want;
      if (expected_means.size() == 0) begin
        $display("%0t: result with none expected: average %0d count %0d",
                 $time, got.average, got.samples_in_window);
        mismatches++;
        return;
      end
      want = expected_means.pop_front();
      if (got.average !== want.average) begin
        $display("%0t: average mismatch: expected %0d actual %0d",
                 $time, want.average, got.average);
        mismatches++;
      end
      if (got.samples_in_window !== want.samples_in_window) begin
        $display("%0t: samples_in_window mismatch: expected %0d actual %0d",
                 $time, want.samples_in_window, got.samples_in_window);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  tma_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  tma_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Idle percentages for each side, changed between phases
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // Long receiver hold-off: the sender bumps hold_asks, the receiver
  // process notices the change and counts the hold down on its own.
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned cycles = 0;

  window_mean_tracker means;

  trailing_moving_average_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5ns clk = ~clk;

  // Watchdog: a hung block ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stall is driven on the falling edge, so at the rising
  // edge both out_valid and out_stall are settled.
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) means.check_mean(out_data);
  end

  task automatic set_pace(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Entered and left just after a falling edge. Valid stays high from one
  // transfer to the next unless the sender picks an idle cycle, so each
  // time step sees at most one update of in_valid.
  task automatic send_item(logic signed [SAMPLE_W-1:0] smp, logic new_series);
    tma_in_t item;
    item.sample  = smp;
    item.restart = new_series;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    means.take_sample(item);
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected mean has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (means.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Length writes only land on an idle block
  task automatic write_window(logic [CNT_W-1:0] len);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    means.set_window(len);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase. Samples lean on the extremes and on small values
  // near zero so sums both saturate the range and cancel; restart_pm sets
  // how often (per thousand) a new series starts. hold_at and pause_at pick
  // the item where the receiver hold-off or a full sender pause happens.
  task automatic run_phase(logic [CNT_W-1:0] len, int unsigned count,
                           int unsigned restart_pm, int unsigned hold_at,
                           int unsigned pause_at);
    logic signed [SAMPLE_W-1:0] smp;
    write_window(len);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == hold_at) hold_asks++;
      if (n == pause_at) wait_drained();
      case ($urandom_range(7))
        0:       smp = 32'sh7FFF_FFFF;
        1:       smp = 32'sh8000_0000;
        2:       smp = $urandom_range(131071) - 65536;
        default: smp = $urandom;
      endcase
      send_item(smp, $urandom_range(999) < restart_pm);
    end
  endtask

  initial begin
    means = new();
    set_pace(33, 85);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset length of 100: full-scale sums, then a new
    // series checking truncation toward zero on both signs.
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(-1, 1'b1);
    send_item(0, 1'b0);
    send_item(3, 1'b0);
    send_item(-7, 1'b0);

    // Length one: each mean is the sample itself
    write_window(1);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(-5, 1'b1);

    // Length zero behaves as one
    write_window(0);
    send_item(7, 1'b0);
    send_item(-9, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);

    // All-ones length saturates to the store depth
    write_window(2047);
    send_item(1, 1'b0);
    send_item(32'sh0001_0000, 1'b0);
    send_item(-65537, 1'b0);

    write_window(CNT_W'(WINDOW_MAX));
    send_item(32'sh7FFF_FFFF, 1'b1);
    send_item(32'sh7FFF_FFFF, 1'b0);

    // Just past the depth: saturates too
    write_window(CNT_W'(WINDOW_MAX + 1));
    send_item(32'sh8000_0000, 1'b0);
    send_item(-1, 1'b0);

    // Length two: window slides after the second sample
    write_window(2);
    send_item(5, 1'b0);
    send_item(-6, 1'b0);
    send_item(1, 1'b0);

    // Random part. Small windows with frequent restarts first, both sides
    // idling; the sender idles lightly and the receiver heavily.
    run_phase(3, 150, 20, 0, 0);
    run_phase(0, 80, 20, 0, 0);
    run_phase(17, 150, 20, 0, 0);

    // One long series at full depth with no restart: the window fills,
    // starts dropping old samples and the write position wraps.
    set_pace(85, 33);
    run_phase(2047, 1100, 0, 1100, 1100);

    // No idling. A long receiver hold-off backs the job queue up into the
    // input, and later a sender pause lets the block drain completely.
    set_pace(0, 0);
    run_phase(1, 100, 20, 10, 100);
    run_phase(CNT_W'($urandom_range(64, 2)), 150, 20, 150, 75);
    run_phase(CNT_W'($urandom_range(WINDOW_MAX, 1)), 200, 5, 200, 200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (means.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tma_pkg.sv
hw/rtl/tma_front.sv
hw/rtl/tma_fifo.sv
hw/rtl/tma_div.sv
hw/rtl/trailing_moving_average_core.sv
sim/testbench.sv
